>>> rtl/core/vsp_pkg.sv
// ----------------------------------------------------------------------------
// VCO synthesizer programmer package
// Shared types, frame constants and the band and channel frequency table.
// ----------------------------------------------------------------------------
`default_nettype none

package vsp_pkg;

    localparam int BANDS       = 5;
    localparam int CHANNELS    = 8;
    localparam int TAB_BANDS   = 5;
    localparam int TAB_CHANS   = 8;
    localparam int BAND_MAX    = (BANDS < TAB_BANDS) ? BANDS : TAB_BANDS;
    localparam int CHAN_MAX    = (CHANNELS < TAB_CHANS) ? CHANNELS : TAB_CHANS;
    localparam int QUEUE_DEPTH = 2;

    localparam int FRAME_BITS = 25;
    localparam int FREQ_W     = 13;
    localparam int DATA_W     = 20;
    localparam int PROD_W     = 18;
    localparam int FREQ_MULT  = 25;

    localparam logic [3:0]        ADDR_REF  = 4'h0;
    localparam logic [3:0]        ADDR_NA   = 4'h1;
    localparam logic [DATA_W-1:0] REF_DIV   = 20'd400;

    localparam logic                  OP_FREQ = 1'b0;
    localparam logic                  OP_CHAN = 1'b1;

    localparam logic [FRAME_BITS-1:0] FRAME_REF = {REF_DIV, 1'b1, ADDR_REF};

    typedef struct packed {
        logic              op;
        logic [FREQ_W-1:0] freq_mhz;
        logic [2:0]        band;
        logic [3:0]        channel;
    } t_cmd;

    typedef struct packed {
        logic       mosi_bit;
        logic       frame_index;
        logic [4:0] bit_index;
        logic       frame_end;
        logic       error;
        logic       last;
    } t_result;

    typedef struct packed {
        logic              err;
        logic [DATA_W-1:0] na_data;
    } t_job;

    typedef logic [TAB_CHANS-1:0][FREQ_W-1:0] t_row;

    function automatic t_row band_row(input logic [2:0] b);
        t_row row;
        case (b)
            3'd0: row = {13'd5725, 13'd5746, 13'd5765, 13'd5785,
                         13'd5805, 13'd5825, 13'd5846, 13'd5865};
            3'd1: row = {13'd5866, 13'd5847, 13'd5828, 13'd5809,
                         13'd5790, 13'd5771, 13'd5752, 13'd5733};
            3'd2: row = {13'd5905, 13'd5905, 13'd5905, 13'd5885,
                         13'd5665, 13'd5665, 13'd5685, 13'd5705};
            3'd3: row = {13'd5880, 13'd5860, 13'd5840, 13'd5820,
                         13'd5800, 13'd5780, 13'd5760, 13'd5740};
            3'd4: row = {13'd5917, 13'd5880, 13'd5843, 13'd5806,
                         13'd5769, 13'd5732, 13'd5695, 13'd5658};
            default: row = '0;
        endcase
        return row;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/vsp_front.sv
// ----------------------------------------------------------------------------
// VCO synthesizer programmer front end
// Holds the enable register, validates commands, looks up the channel
// frequency and forms the N and A counter data word for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module vsp_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire vsp_pkg::t_cmd i_cmd,
    input  wire logic          i_q_full,
    input  wire logic          i_cfg_valid,
    input  wire logic          i_cfg_data,
    output logic               o_cfg_ready,
    output logic               o_job_push,
    output vsp_pkg::t_job      o_job
);
    import vsp_pkg::*;

    logic              r_enable;
    logic              n_enable;
    logic              accept;
    logic              band_ok;
    logic              chan_ok;
    logic              bad;
    logic [2:0]        band_idx;
    logic [2:0]        chan_idx;
    t_row              row;
    logic [FREQ_W-1:0] freq;
    logic [PROD_W-1:0] g;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_push && !i_q_full;

    assign band_ok  = (i_cmd.band != 3'd0) && (32'(i_cmd.band) <= 32'(BAND_MAX));
    assign chan_ok  = (i_cmd.channel != 4'd0) && (32'(i_cmd.channel) <= 32'(CHAN_MAX));
    assign bad      = (i_cmd.op == OP_CHAN) && !(band_ok && chan_ok);
    assign band_idx = i_cmd.band - 3'd1;
    assign chan_idx = 3'(i_cmd.channel - 4'd1);
    assign row      = band_row(band_idx);
    assign freq     = (i_cmd.op == OP_CHAN) ? row[chan_idx] : i_cmd.freq_mhz;
    assign g        = PROD_W'(freq) * PROD_W'(FREQ_MULT);

    always_comb begin
        o_job.err     = bad;
        o_job.na_data = {1'b0, g[17:6], 1'b0, g[5:0]};
        o_job_push    = accept && r_enable;
    end

    always_comb begin
        n_enable = r_enable;
        if (i_cfg_valid) begin
            n_enable = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else begin
            r_enable <= n_enable;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/vsp_queue.sv
// ----------------------------------------------------------------------------
// VCO synthesizer programmer job queue
// Short first-in first-out queue of prepared jobs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module vsp_queue #(
    parameter int DEPTH = vsp_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire vsp_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output vsp_pkg::t_job      o_job
);
    import vsp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/vsp_back.sv
// ----------------------------------------------------------------------------
// VCO synthesizer programmer back end
// Serializes the reference and N and A counter frames one bit per beat,
// or gives a single error beat for a rejected command.
// ----------------------------------------------------------------------------
`default_nettype none

module vsp_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire vsp_pkg::t_job i_job,
    output logic               o_q_pop,
    output logic               o_empty,
    input  wire logic          i_pop,
    output vsp_pkg::t_result   o_result
);
    import vsp_pkg::*;

    localparam logic [4:0] LAST_BIT = 5'(FRAME_BITS - 1);

    logic                  r_active;
    logic                  n_active;
    logic                  r_err;
    logic                  n_err;
    logic [FRAME_BITS-1:0] r_frame;
    logic [FRAME_BITS-1:0] n_frame;
    logic                  r_fi;
    logic                  n_fi;
    logic [4:0]            r_bi;
    logic [4:0]            n_bi;
    logic                  beat;
    logic                  load;
    logic                  at_end;

    assign o_empty = !r_active;
    assign beat    = i_pop && r_active;
    assign at_end  = (r_bi == LAST_BIT);
    assign load    = !r_active || (beat && o_result.last);
    assign o_q_pop = load && i_q_valid;

    always_comb begin
        o_result.mosi_bit    = !r_err && (r_fi ? r_frame[r_bi] : FRAME_REF[r_bi]);
        o_result.frame_index = r_fi;
        o_result.bit_index   = r_bi;
        o_result.frame_end   = !r_err && at_end;
        o_result.error       = r_err;
        o_result.last        = r_err || (r_fi && at_end);
    end

    always_comb begin
        n_active = r_active;
        n_err    = r_err;
        n_frame  = r_frame;
        n_fi     = r_fi;
        n_bi     = r_bi;
        if (load) begin
            n_active = i_q_valid;
            n_err    = i_job.err;
            n_frame  = {i_job.na_data, 1'b1, ADDR_NA};
            n_fi     = 1'b0;
            n_bi     = '0;
        end else if (beat) begin
            if (at_end) begin
                n_fi = 1'b1;
                n_bi = '0;
            end else begin
                n_bi = r_bi + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_fi     <= 1'b0;
            r_bi     <= '0;
        end else begin
            r_active <= n_active;
            r_fi     <= n_fi;
            r_bi     <= n_bi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err   <= n_err;
        r_frame <= n_frame;
    end

`ifndef ASSERT_OFF
    a_mid_cmd_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !o_empty && !o_result.last) |=> !o_empty)
        else $error("Result channel went empty in the middle of a command.");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_result.bit_index <= LAST_BIT))
        else $error("Bit index beyond the frame length.");

    a_bit_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !o_empty && !o_result.last && !o_result.frame_end)
        |=> (o_result.bit_index == $past(o_result.bit_index) + 5'd1))
        else $error("Bit index did not advance by one.");
`endif

endmodule

`default_nettype wire

>>> rtl/core/vco_synth_spi_programmer.sv
// ----------------------------------------------------------------------------
// VCO synthesizer SPI programmer
// A command is written into the job queue and then loaded into the serializer before its first result beat is shown.
// Throughput: 50 result beats per valid command, one for a rejected one,
// none when disabled; the serializer emits one bit per cycle while popped.
// Reset clears the enable register, the job queue and the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module vco_synth_spi_programmer #(
    parameter int QUEUE_DEPTH = vsp_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    input  wire vsp_pkg::t_cmd i_cmd,
    output logic               full,
    input  wire logic          i_cfg_valid,
    input  wire logic          i_cfg_data,
    output logic               o_cfg_ready,
    output logic               empty,
    input  wire logic          pop,
    output vsp_pkg::t_result   o_result
);
    import vsp_pkg::*;

    logic job_push;
    t_job front_job;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_job q_job;

    assign full = q_full;

    vsp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_cmd       (i_cmd),
        .i_q_full    (q_full),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_job_push  (job_push),
        .o_job       (front_job)
    );

    vsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    vsp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (q_job),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// VCO synthesizer SPI programmer testbench
// Drives tune commands by frequency and by band and channel, toggles the
// enable register between phases, and checks every serial result beat
// field by field against a frame predictor. Both the command and the result
// side idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import vsp_pkg::*;

    typedef enum logic [1:0] {
        ROW_MODEL,
        ROW_NONE,
        ROW_ERR
    } t_row_kind;

    typedef struct packed {
        logic              en;
        t_row_kind         kind;
        logic              op;
        logic [FREQ_W-1:0] freq;
        logic [2:0]        band;
        logic [3:0]        chan;
    } t_stim_row;

    localparam int DIR_ROWS     = 23;
    localparam int RANDOM_ITEMS = 210;
    localparam int PAUSE_AT     = 120;
    localparam int SETTLE_CYCLES = 10;
    localparam int TAIL_CYCLES  = 20;
    localparam int STALL_LIMIT  = 4000;

    localparam logic [0:39][12:0] CHAN_MHZ = {
        13'd5865, 13'd5846, 13'd5825, 13'd5805, 13'd5785, 13'd5765, 13'd5746, 13'd5725,
        13'd5733, 13'd5752, 13'd5771, 13'd5790, 13'd5809, 13'd5828, 13'd5847, 13'd5866,
        13'd5705, 13'd5685, 13'd5665, 13'd5665, 13'd5885, 13'd5905, 13'd5905, 13'd5905,
        13'd5740, 13'd5760, 13'd5780, 13'd5800, 13'd5820, 13'd5840, 13'd5860, 13'd5880,
        13'd5658, 13'd5695, 13'd5732, 13'd5769, 13'd5806, 13'd5843, 13'd5880, 13'd5917
    };

    localparam t_result ERR_BEAT = '{mosi_bit: 1'b0, frame_index: 1'b0, bit_index: 5'd0,
                                     frame_end: 1'b0, error: 1'b1, last: 1'b1};

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      push        = 1'b0;
    t_cmd      i_cmd       = '0;
    logic      full;
    logic      i_cfg_valid = 1'b0;
    logic      i_cfg_data  = 1'b0;
    logic      o_cfg_ready;
    logic      empty;
    logic      pop         = 1'b0;
    t_result   o_result;
    t_row_kind row_kind    = ROW_MODEL;

    t_result   expected_beats[$];
    t_stim_row dir_rows[0:DIR_ROWS-1];
    logic      en_model      = 1'b0;
    int        mismatches    = 0;
    int        cmds_taken    = 0;
    int        beats_checked = 0;
    int        error_beats   = 0;
    int        cfg_writes    = 0;
    int        idle_cycles   = 0;

    vco_synth_spi_programmer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_cmd       (i_cmd),
        .full        (full),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report($sformatf("beat %0d field %s: got %0d, expected %0d",
                             beats_checked, name, got, want));
        end
    endtask

    function automatic void predict_frames(input t_cmd c);
        logic [FREQ_W-1:0]        mhz;
        logic [17:0]              g;
        logic [DATA_W-1:0]        na;
        logic [1:0][FRAME_BITS-1:0] frames;
        t_result                  beat;
        int                       f;
        int                       b;
        if (!en_model) begin
            return;
        end
        if (c.op == OP_CHAN) begin
            if (c.band < 1 || c.band > BAND_MAX || c.channel < 1 || c.channel > CHAN_MAX) begin
                expected_beats.push_back(ERR_BEAT);
                return;
            end
            mhz = CHAN_MHZ[(int'(c.band) - 1) * TAB_CHANS + int'(c.channel) - 1];
        end else begin
            mhz = c.freq_mhz;
        end
        g = 18'(int'(mhz) * 25);
        na = {1'b0, g[17:6], 1'b0, g[5:0]};
        frames[0] = {REF_DIV, 1'b1, ADDR_REF};
        frames[1] = {na, 1'b1, ADDR_NA};
        for (f = 0; f < 2; f++) begin
            for (b = 0; b < FRAME_BITS; b++) begin
                beat.mosi_bit    = frames[f][b];
                beat.frame_index = f[0];
                beat.bit_index   = b[4:0];
                beat.frame_end   = (b == FRAME_BITS - 1);
                beat.error       = 1'b0;
                beat.last        = (f == 1 && b == FRAME_BITS - 1);
                expected_beats.push_back(beat);
            end
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                en_model = i_cfg_data;
                cfg_writes++;
            end
            if (push && !full) begin
                cmds_taken++;
                case (row_kind)
                    ROW_MODEL: predict_frames(i_cmd);
                    ROW_ERR:   expected_beats.push_back(ERR_BEAT);
                    default:   ;
                endcase
            end
            if (pop && !empty) begin
                if (expected_beats.size() == 0) begin
                    report($sformatf("result beat %h with nothing expected", o_result));
                end else begin
                    want = expected_beats.pop_front();
                    check_field("mosi_bit", o_result.mosi_bit, want.mosi_bit);
                    check_field("frame_index", o_result.frame_index, want.frame_index);
                    check_field("bit_index", o_result.bit_index, want.bit_index);
                    check_field("frame_end", o_result.frame_end, want.frame_end);
                    check_field("error", o_result.error, want.error);
                    check_field("last", o_result.last, want.last);
                    if (want.error) begin
                        error_beats++;
                    end
                end
                beats_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("tb failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 120);
    endfunction

    initial begin : result_drain
        int run;
        int gap;
        @(posedge i_clk);
        forever begin
            run = $urandom_range(1, 40);
            pop <= 1'b1;
            repeat (run) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    task automatic send_cmd(input t_cmd c, input t_row_kind kind);
        push     <= 1'b1;
        i_cmd    <= c;
        row_kind <= kind;
        do @(posedge i_clk); while (full);
    endtask

    task automatic idle_sender();
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        push <= 1'b0;
        do @(posedge i_clk); while (expected_beats.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_enable(input logic en);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= en;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_cmd random_cmd();
        t_cmd c;
        c.op       = 1'($urandom_range(0, 1));
        c.freq_mhz = 13'($urandom_range(0, 8191));
        c.band     = 3'($urandom_range(0, 7));
        c.channel  = 4'($urandom_range(0, 15));
        if (c.op == OP_CHAN && $urandom_range(0, 9) < 8) begin
            c.band    = 3'($urandom_range(1, BAND_MAX));
            c.channel = 4'($urandom_range(1, CHAN_MAX));
        end else if (c.op == OP_FREQ && $urandom_range(0, 3) == 0) begin
            c.freq_mhz = 13'($urandom_range(5600, 6000));
        end
        return c;
    endfunction

    initial begin : stimulus
        t_cmd c;
        logic en_now;
        logic en;
        logic paused;
        int   len;
        int   counted;
        int   i;

        en_now  = 1'b0;
        paused  = 1'b0;
        counted = 0;

        // Rows typed as NONE are sent while disabled, ERR rows expect one error beat.
        dir_rows = '{
            '{1'b0, ROW_NONE,  OP_CHAN, 13'd0,    3'd1, 4'd1},
            '{1'b0, ROW_NONE,  OP_FREQ, 13'd5800, 3'd0, 4'd0},
            '{1'b0, ROW_NONE,  OP_CHAN, 13'd0,    3'd0, 4'd0},
            '{1'b1, ROW_MODEL, OP_FREQ, 13'd0,    3'd0, 4'd0},
            '{1'b1, ROW_MODEL, OP_FREQ, 13'd8191, 3'd0, 4'd0},
            '{1'b1, ROW_MODEL, OP_FREQ, 13'd5800, 3'd1, 4'd1},
            '{1'b1, ROW_MODEL, OP_FREQ, 13'h1555, 3'd7, 4'd15},
            '{1'b1, ROW_MODEL, OP_FREQ, 13'h0aaa, 3'd0, 4'd0},
            '{1'b1, ROW_MODEL, OP_CHAN, 13'd0,    3'd1, 4'd1},
            '{1'b1, ROW_MODEL, OP_CHAN, 13'd0,    3'd1, 4'd8},
            '{1'b1, ROW_MODEL, OP_CHAN, 13'd0,    3'd5, 4'd1},
            '{1'b1, ROW_MODEL, OP_CHAN, 13'd0,    3'd5, 4'd8},
            '{1'b1, ROW_MODEL, OP_CHAN, 13'd8191, 3'd3, 4'd4},
            '{1'b1, ROW_ERR,   OP_CHAN, 13'd0,    3'd0, 4'd1},
            '{1'b1, ROW_ERR,   OP_CHAN, 13'd0,    3'd6, 4'd1},
            '{1'b1, ROW_ERR,   OP_CHAN, 13'd8191, 3'd7, 4'd15},
            '{1'b1, ROW_ERR,   OP_CHAN, 13'd0,    3'd1, 4'd0},
            '{1'b1, ROW_ERR,   OP_CHAN, 13'd0,    3'd1, 4'd9},
            '{1'b1, ROW_ERR,   OP_CHAN, 13'd0,    3'd5, 4'd15},
            '{1'b1, ROW_ERR,   OP_CHAN, 13'd0,    3'd0, 4'd0},
            '{1'b0, ROW_NONE,  OP_CHAN, 13'd0,    3'd7, 4'd15},
            '{1'b0, ROW_NONE,  OP_FREQ, 13'd8191, 3'd0, 4'd0},
            '{1'b1, ROW_MODEL, OP_CHAN, 13'd0,    3'd2, 4'd5}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].en != en_now) begin
                drain_results();
                write_enable(dir_rows[i].en);
                en_now = dir_rows[i].en;
            end
            c.op       = dir_rows[i].op;
            c.freq_mhz = dir_rows[i].freq;
            c.band     = dir_rows[i].band;
            c.channel  = dir_rows[i].chan;
            send_cmd(c, dir_rows[i].kind);
            idle_sender();
        end

        while (counted < RANDOM_ITEMS) begin
            en  = ($urandom_range(0, 3) != 0);
            len = en ? $urandom_range(20, 60) : $urandom_range(3, 8);
            if (en != en_now) begin
                drain_results();
                write_enable(en);
                en_now = en;
            end
            repeat (len) begin
                send_cmd(random_cmd(), ROW_MODEL);
                if (en) begin
                    counted++;
                end
                if (!paused && counted >= PAUSE_AT) begin
                    // Hold the command side until every pending beat has been popped.
                    paused = 1'b1;
                    drain_results();
                end else begin
                    idle_sender();
                end
            end
        end

        push <= 1'b0;
        do @(posedge i_clk); while (expected_beats.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_beats.size() != 0) begin
            report($sformatf("%0d expected result beats never arrived",
                             expected_beats.size()));
        end

        $display("Covered %0d commands and %0d result beats, %0d of them error beats.",
                 cmds_taken, beats_checked, error_beats);
        $display("The enable register was written %0d times, with %0d mismatches seen.",
                 cfg_writes, mismatches);
        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/vsp_pkg.sv
rtl/core/vsp_front.sv
rtl/core/vsp_queue.sv
rtl/core/vsp_back.sv
rtl/core/vco_synth_spi_programmer.sv
sim/tb.sv
